/* sv/slec_pkg.sv */
// shared types and constants for the sequential list engine
package slec_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = 5;
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_LOCATE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ERR_FULL,
    OP_ERR_POS,
    OP_INS_START,
    OP_INS_STEP,
    OP_INS_WRITE,
    OP_READ_POS,
    OP_CAPTURE,
    OP_DEL_STEP,
    OP_LOC_START,
    OP_LOC_STEP,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_STEP,
    S_INS_WRITE,
    S_DEL_CAP,
    S_DEL_STEP,
    S_GET_CAP,
    S_LOC_STEP,
    S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic ins_pos_ok;
    logic rd_pos_ok;
    logic ins_more;
    logic fwd_more;
    logic pend;
    logic match;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/slec_if.sv */
// handshake channels for list commands and list results
interface slec_in_if;
  import slec_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [CNT_W-1:0]         position;
  logic signed [WORD_W-1:0] value;
  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface slec_out_if;
  import slec_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] result_value;
  logic [CNT_W-1:0]         found_position;
  logic [CNT_W-1:0]         count;
  modport source (output valid, output status, output result_value,
                  output found_position, output count, input ready);
  modport sink   (input valid, input status, input result_value,
                  input found_position, input count, output ready);
endinterface

/* sv/slec_ctrl.sv */
// sequencing state machine for the list engine
module slec_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  slec_pkg::dp_stat_t stat,
  output slec_pkg::dp_cmd_t  dp_cmd
);
  import slec_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dp_cmd.op = OP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.op = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_INSERT: begin
            if (stat.full) begin
              dp_cmd.op = OP_ERR_FULL;
              state_nxt = S_DONE;
            end else if (!stat.ins_pos_ok) begin
              dp_cmd.op = OP_ERR_POS;
              state_nxt = S_DONE;
            end else begin
              dp_cmd.op = OP_INS_START;
              state_nxt = S_INS_STEP;
            end
          end
          CMD_DELETE, CMD_GET: begin
            if (!stat.rd_pos_ok) begin
              dp_cmd.op = OP_ERR_POS;
              state_nxt = S_DONE;
            end else begin
              dp_cmd.op = OP_READ_POS;
              state_nxt = (stat.cmd == CMD_DELETE) ? S_DEL_CAP : S_GET_CAP;
            end
          end
          CMD_LOCATE: begin
            dp_cmd.op = OP_LOC_START;
            state_nxt = S_LOC_STEP;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INS_STEP: begin
        dp_cmd.op = OP_INS_STEP;
        if (!stat.ins_more) begin
          state_nxt = S_INS_WRITE;
        end
      end
      S_INS_WRITE: begin
        dp_cmd.op = OP_INS_WRITE;
        state_nxt = S_DONE;
      end
      S_DEL_CAP: begin
        dp_cmd.op = OP_CAPTURE;
        state_nxt = S_DEL_STEP;
      end
      S_DEL_STEP: begin
        dp_cmd.op = OP_DEL_STEP;
        if (!stat.fwd_more) begin
          state_nxt = S_DONE;
        end
      end
      S_GET_CAP: begin
        dp_cmd.op = OP_CAPTURE;
        state_nxt = S_DONE;
      end
      S_LOC_STEP: begin
        dp_cmd.op = OP_LOC_STEP;
        if (stat.match || (!stat.fwd_more && !stat.pend)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          dp_cmd.op = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* sv/slec_dp.sv */
// list storage, length, walk cursor and result registers
module slec_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  slec_pkg::dp_cmd_t                 dp_cmd,
  output slec_pkg::dp_stat_t                stat,
  input  logic [1:0]                        in_cmd,
  input  logic [slec_pkg::CNT_W-1:0]        in_position,
  input  logic signed [slec_pkg::WORD_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic signed [slec_pkg::WORD_W-1:0] out_result_value,
  output logic [slec_pkg::CNT_W-1:0]        out_found_position,
  output logic [slec_pkg::CNT_W-1:0]        out_count
);
  import slec_pkg::*;

  logic [WORD_W-1:0] mem [CAPACITY];

  cmd_t              cmd_r;
  logic [CNT_W-1:0]  pos_r;
  logic [WORD_W-1:0] val_r;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic [WORD_W-1:0] rdata_r;
  status_t           res_status_r, res_status_nxt;
  logic [WORD_W-1:0] res_value_r, res_value_nxt;
  logic [CNT_W-1:0]  res_fpos_r, res_fpos_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [WORD_W-1:0] out_value_r;
  logic [CNT_W-1:0]  out_fpos_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [CNT_W-1:0]  cur_dec, cur_inc, pos_dec, pend_inc;
  logic              out_free;

  assign cur_dec  = cur_r - CNT_W'(1);
  assign cur_inc  = cur_r + CNT_W'(1);
  assign pos_dec  = pos_r - CNT_W'(1);
  assign pend_inc = CNT_W'(pend_addr_r) + CNT_W'(1);
  assign out_free = !out_valid_r || out_ready;

  // status towards the sequencer
  always_comb begin
    stat.cmd        = cmd_r;
    stat.full       = (len_r == CNT_W'(CAPACITY));
    stat.ins_pos_ok = (pos_r != '0) &&
                      ({1'b0, pos_r} <= ({1'b0, len_r} + (CNT_W+1)'(1)));
    stat.rd_pos_ok  = (pos_r != '0) && (pos_r <= len_r);
    stat.ins_more   = (cur_r >= pos_r);
    stat.fwd_more   = (cur_r < len_r);
    stat.pend       = pend_r;
    stat.match      = pend_r && (rdata_r == val_r);
    stat.out_free   = out_free;
  end

  always_comb begin
    rd_en          = 1'b0;
    rd_addr        = cur_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = pend_addr_r;
    wr_data        = rdata_r;
    len_nxt        = len_r;
    cur_nxt        = cur_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_fpos_nxt   = res_fpos_r;
    unique case (dp_cmd.op)
      OP_ERR_FULL, OP_ERR_POS: begin
        res_status_nxt = (dp_cmd.op == OP_ERR_FULL) ? ST_FULL : ST_BAD_POS;
        res_value_nxt  = '0;
        res_fpos_nxt   = '0;
      end
      OP_INS_START: begin
        cur_nxt  = len_r;
        pend_nxt = 1'b0;
      end
      OP_INS_STEP: begin
        // walk downwards, each write following its read in the next step
        wr_en = pend_r;
        if (stat.ins_more) begin
          rd_en         = 1'b1;
          rd_addr       = cur_dec[IDX_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = cur_r[IDX_W-1:0];
          cur_nxt       = cur_dec;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      OP_INS_WRITE: begin
        wr_en          = 1'b1;
        wr_addr        = pos_dec[IDX_W-1:0];
        wr_data        = val_r;
        len_nxt        = len_r + CNT_W'(1);
        res_status_nxt = ST_OK;
        res_value_nxt  = '0;
        res_fpos_nxt   = '0;
      end
      OP_READ_POS: begin
        rd_en    = 1'b1;
        rd_addr  = pos_dec[IDX_W-1:0];
        cur_nxt  = pos_r;
        pend_nxt = 1'b0;
      end
      OP_CAPTURE: begin
        res_status_nxt = ST_OK;
        res_value_nxt  = rdata_r;
        res_fpos_nxt   = '0;
      end
      OP_DEL_STEP: begin
        // walk upwards, each word moved down one place
        wr_en = pend_r;
        if (stat.fwd_more) begin
          rd_en         = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = cur_dec[IDX_W-1:0];
          cur_nxt       = cur_inc;
        end else begin
          pend_nxt = 1'b0;
          len_nxt  = len_r - CNT_W'(1);
        end
      end
      OP_LOC_START: begin
        cur_nxt        = '0;
        pend_nxt       = 1'b0;
        res_status_nxt = ST_NOT_FOUND;
        res_value_nxt  = '0;
        res_fpos_nxt   = '0;
      end
      OP_LOC_STEP: begin
        if (stat.match) begin
          res_status_nxt = ST_OK;
          res_fpos_nxt   = pend_inc;
          pend_nxt       = 1'b0;
        end else if (stat.fwd_more) begin
          rd_en         = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = cur_r[IDX_W-1:0];
          cur_nxt       = cur_inc;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // storage with a write port and a registered read port: one write and one read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_LOAD) begin
      cmd_r <= cmd_t'(in_cmd);
      pos_r <= in_position;
      val_r <= in_value;
    end
    cur_r        <= cur_nxt;
    pend_addr_r  <= pend_addr_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_fpos_r   <= res_fpos_nxt;
    if (dp_cmd.op == OP_EMIT) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_fpos_r   <= res_fpos_r;
      out_count_r  <= len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      pend_r <= pend_nxt;
      if (dp_cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_value   = out_value_r;
  assign out_found_position = out_fpos_r;
  assign out_count          = out_count_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CNT_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("shift read and write hit the same entry");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == OP_EMIT) |-> out_free)
    else $error("result overwritten before it was taken");

  a_len_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (len_r != $past(len_r))) |->
      ($past(dp_cmd.op) == OP_INS_WRITE || $past(dp_cmd.op) == OP_DEL_STEP))
    else $error("length changed outside insert or delete");

endmodule

/* sv/sequential_list_engine_core.sv */
// top level of the sequential list engine: sequencer plus list datapath
// sequence: get decodes, reads and captures the word, then hands over the result;
//   an error goes from decode straight to the result; insert and delete walk the
//   entries they move, locate the entries it scans; one word at a time, with the
//   walk through the store at one read and one write a cycle
// a new word is taken while the previous result still waits on the output
// reset (rst_n, synchronous, active low) empties the list; stored words are
//   never read before they are written, so the store itself is not cleared
module sequential_list_engine_core (
  input logic        clk,
  input logic        rst_n,
  slec_in_if.sink    in_if,
  slec_out_if.source out_if
);
  import slec_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: decodes the word, walks the store, hands over the result
  slec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  // datapath: element store, length, cursor and output register
  slec_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .dp_cmd             (dp_cmd),
    .stat               (dp_stat),
    .in_cmd             (in_if.cmd),
    .in_position        (in_if.position),
    .in_value           (in_if.value),
    .out_valid          (out_if.valid),
    .out_ready          (out_if.ready),
    .out_status         (out_if.status),
    .out_result_value   (out_if.result_value),
    .out_found_position (out_if.found_position),
    .out_count          (out_if.count)
  );

endmodule

/* verif/sequential_list_engine_core_checker.sv */
// checker for the sequential list engine: predicts each reply and compares it on arrival
module sequential_list_engine_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  slec_in_if          in_mon,
  slec_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  import slec_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] value;
    logic [CNT_W-1:0]         found;
    logic [CNT_W-1:0]         count;
  } list_reply_t;

  // shadow copy of the list
  logic signed [WORD_W-1:0] list_words [CAPACITY];
  int                       words_held;
  list_reply_t              replies_due [$];

  // applies one command to the shadow list and returns the reply it should give
  function automatic list_reply_t run_list_cmd(cmd_t c, logic [CNT_W-1:0] p,
                                               logic signed [WORD_W-1:0] v);
    list_reply_t r;
    int          k;
    r.status = ST_OK;
    r.value  = '0;
    r.found  = '0;
    case (c)
      CMD_INSERT: begin
        if (words_held >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > words_held + 1) begin
          r.status = ST_BAD_POS;
        end else begin
          for (k = words_held; k >= p; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = v;
          words_held++;
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > words_held) begin
          r.status = ST_BAD_POS;
        end else begin
          r.value = list_words[p-1];
          for (k = p; k < words_held; k++) list_words[k-1] = list_words[k];
          words_held--;
        end
      end
      CMD_GET: begin
        if (p < 1 || p > words_held) r.status = ST_BAD_POS;
        else r.value = list_words[p-1];
      end
      default: begin
        r.status = ST_NOT_FOUND;
        for (k = 0; k < words_held; k++) begin
          if (list_words[k] == v) begin
            r.status = ST_OK;
            r.found  = CNT_W'(k + 1);
            break;
          end
        end
      end
    endcase
    r.count = CNT_W'(words_held);
    return r;
  endfunction

  always @(posedge clk) begin
    list_reply_t want;
    list_reply_t got;
    if (!rst_n) begin
      replies_due.delete();
      words_held = 0;
      fail_count = 0;
      pending    = 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got.status = status_t'(out_mon.status);
        got.value  = out_mon.result_value;
        got.found  = out_mon.found_position;
        got.count  = out_mon.count;
        if (replies_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected reply: st=%0d val=%0d fpos=%0d cnt=%0d",
                     got.status, got.value, got.found, got.count);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.value !== want.value ||
              got.found !== want.found || got.count !== want.count) begin
            if (fail_count < 10)
              $display({"reply differs: exp st=%0d val=%0d fpos=%0d cnt=%0d, ",
                        "got st=%0d val=%0d fpos=%0d cnt=%0d"},
                       want.status, want.value, want.found, want.count,
                       got.status, got.value, got.found, got.count);
            fail_count++;
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        replies_due.push_back(run_list_cmd(cmd_t'(in_mon.cmd), in_mon.position,
                                           in_mon.value));
      pending = replies_due.size();
    end
  end

endmodule

/* verif/sequential_list_engine_core_tb.sv */
// testbench top for the sequential list engine: clock, reset, stimulus and verdict
module sequential_list_engine_core_tb;
  import slec_pkg::*;

  localparam int RANDOM_WORDS = 1950;
  localparam int CYCLE_LIMIT  = 1000000;
  // extra wait after the last reply, sized from CAPACITY to cover a whole walk of the store
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // quiet stretches: no idling on either side
  logic                     quiet_phase = 1'b0;
  // rough length of the list, only used to steer positions into range
  int                       shadow_len  = 0;
  logic signed [WORD_W-1:0] last_value  = '0;

  slec_in_if  in_ch ();
  slec_out_if out_ch ();

  sequential_list_engine_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  sequential_list_engine_core_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sequential_list_engine_core: mismatch");
      $finish;
    end
  end

  // gap before a word: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // mostly an in-range position, sometimes anything the field can hold
  function automatic logic [CNT_W-1:0] pick_position(cmd_t c);
    int top_pos;
    top_pos = (c == CMD_INSERT) ? shadow_len + 1 : shadow_len;
    if (c == CMD_LOCATE || top_pos < 1 || $urandom_range(0, 99) < 12)
      return CNT_W'($urandom_range(0, 31));
    return CNT_W'($urandom_range(1, top_pos));
  endfunction

  // small pool of repeated words so that locate finds matches and duplicates
  function automatic logic signed [WORD_W-1:0] pick_value(cmd_t c);
    int r;
    r = $urandom_range(0, 9);
    if (c == CMD_LOCATE && r < 4) return last_value;
    if (r == 0) return 32'sh8000_0000;
    if (r == 1) return 32'sh7FFF_FFFF;
    if (r < 6) return WORD_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  // grow, shrink or balanced mix of commands
  function automatic cmd_t pick_cmd(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 55) return CMD_INSERT;
        if (r < 70) return CMD_DELETE;
        if (r < 85) return CMD_GET;
        return CMD_LOCATE;
      end
      1: begin
        if (r < 15) return CMD_INSERT;
        if (r < 70) return CMD_DELETE;
        if (r < 85) return CMD_GET;
        return CMD_LOCATE;
      end
      default: return cmd_t'(r % 4);
    endcase
  endfunction

  // offer one word, hold it until taken; valid is only dropped when a gap is wanted
  task automatic send_word(input cmd_t c, input logic [CNT_W-1:0] p,
                           input logic signed [WORD_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.position <= p;
    in_ch.value    <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // keep the steering estimate in step with what the list should now hold
    case (c)
      CMD_INSERT: if (shadow_len < CAPACITY && p >= 1 && p <= shadow_len + 1) shadow_len++;
      CMD_DELETE: if (p >= 1 && p <= shadow_len) shadow_len--;
      default: ;
    endcase
    if (c == CMD_INSERT) last_value = v;
  endtask

  // result side: ready mostly high, short stalls often, long ones rarely
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet_phase && $urandom_range(0, 99) < 20) begin
        out_ch.ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int   k;
    int   n;
    int   mode;
    cmd_t c;
    logic [CNT_W-1:0] p;

    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_INSERT;
    in_ch.position = '0;
    in_ch.value    = '0;
    rst_n          = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list: reads, delete and a position below range are all refused
    send_word(CMD_GET, 5'd1, '0);
    send_word(CMD_DELETE, 5'd1, '0);
    send_word(CMD_LOCATE, 5'd0, 32'sd7);
    send_word(CMD_INSERT, 5'd0, 32'sd1);

    // extremes of the word at the front, the end and the middle
    send_word(CMD_INSERT, 5'd1, 32'sh7FFF_FFFF);
    send_word(CMD_INSERT, 5'd1, 32'sh8000_0000);
    send_word(CMD_INSERT, 5'd3, 32'sd0);
    send_word(CMD_INSERT, 5'd2, -32'sd1);

    // fill to capacity, with a repeated word so locate must pick the first
    for (k = 0; k < 12; k++) begin
      p = (k % 3 == 0) ? CNT_W'(1) :
          (k % 3 == 1) ? CNT_W'(shadow_len + 1) : CNT_W'(shadow_len / 2 + 1);
      send_word(CMD_INSERT, p, (k % 2 == 0) ? 32'sd7 : ((32'sd1 <<< k) ^ 32'sh5555_5555));
    end

    // full list: the full refusal wins over a bad position
    send_word(CMD_INSERT, 5'd31, 32'sd9);
    send_word(CMD_GET, 5'd16, '0);
    send_word(CMD_GET, 5'd17, '0);
    send_word(CMD_LOCATE, 5'd0, 32'sd7);
    send_word(CMD_LOCATE, 5'd0, 32'sh1234_5678);
    send_word(CMD_DELETE, 5'd16, '0);
    send_word(CMD_DELETE, 5'd1, '0);
    send_word(CMD_DELETE, 5'd0, '0);

    // random part in blocks, each with its own mix and idling mood
    mode = 2;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        mode        = $urandom_range(0, 2);
        quiet_phase = ($urandom_range(0, 3) == 0);
      end
      c = pick_cmd(mode);
      send_word(c, pick_position(c), pick_value(c));
    end
    quiet_phase = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // let every reply come home, then give the block a little longer
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("sequential_list_engine_core: match");
    end else begin
      $display("sequential_list_engine_core: mismatch");
    end
    $finish;
  end

endmodule

/* sequential_list_engine_core.f */
sv/slec_pkg.sv
sv/slec_if.sv
sv/slec_ctrl.sv
sv/slec_dp.sv
sv/sequential_list_engine_core.sv
verif/sequential_list_engine_core_checker.sv
verif/sequential_list_engine_core_tb.sv
